/* rtl/tvms_pkg.sv */
// Shared types, constants and the control program of the two-voice melody sequencer.
package tvms_pkg;

  // Sizes of the note store and the tone sampling.
  localparam int NOTES_PER_CHANNEL  = 64;
  localparam int SAMPLES_PER_PERIOD = 128;
  localparam int VOICES             = 2;
  localparam int MS_PER_SECOND      = 1000;

  // Field and register widths.
  localparam int OP_W     = 2;
  localparam int CH_W     = 1;
  localparam int IDX_W    = 6;
  localparam int HZ_W     = 13;
  localparam int MS_W     = 16;
  localparam int LEN_W    = 7;
  localparam int RELOAD_W = 16;
  localparam int CLK_W    = 28;
  localparam int PRE_W    = 17;
  localparam int MASK_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  // Derived datapath widths.
  localparam int ENTRY_W  = HZ_W + MS_W;
  localparam int DEPTH    = VOICES * NOTES_PER_CHANNEL;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int POS_W    = $clog2(NOTES_PER_CHANNEL + 1);
  localparam int RATE_W   = $clog2(MS_PER_SECOND + 1);
  localparam int SMP_W    = $clog2(SAMPLES_PER_PERIOD + 1);
  localparam int PROD1_W  = PRE_W + HZ_W;
  localparam int DEN_W    = PROD1_W + SMP_W;
  localparam int NUM_W    = CLK_W;
  localparam int CMP_W    = (NUM_W + 1 > DEN_W) ? NUM_W + 1 : DEN_W;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int PC_W     = 5;

  localparam logic [RELOAD_W-1:0] RELOAD_MAX = {RELOAD_W{1'b1}};

  // Item opcodes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_PRE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_PRE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MASK   = 2'd3;

  // Datapath actions of one control word.
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_WRITE,
    ACT_START_SETUP,
    ACT_READ_TICK,
    ACT_MUL_TONE1,
    ACT_MUL_TONE2,
    ACT_DIV_RATE,
    ACT_DIV_CLK,
    ACT_DIV_STEP,
    ACT_MUL_DUR,
    ACT_TONE_CLAMP,
    ACT_TONE_ZERO,
    ACT_DUR_CLAMP,
    ACT_DUR_MAX,
    ACT_DUR_ZERO,
    ACT_EMIT_TICK,
    ACT_EMIT_START,
    ACT_EMIT_FIN
  } act_t;

  // Jump conditions of one control word.
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_BAD,
    COND_IS_WRITE,
    COND_IS_START,
    COND_FINISHED,
    COND_HZ_ZERO,
    COND_MS_ZERO,
    COND_RATE_ZERO,
    COND_DIV_BUSY
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             wait_in;
    logic             wait_out;
  } ucode_t;

  // Program step addresses.
  localparam logic [PC_W-1:0] STEP_IDLE       = 5'd0;
  localparam logic [PC_W-1:0] STEP_CHECK      = 5'd1;
  localparam logic [PC_W-1:0] STEP_TO_WRITE   = 5'd2;
  localparam logic [PC_W-1:0] STEP_TO_START   = 5'd3;
  localparam logic [PC_W-1:0] STEP_TO_FIN     = 5'd4;
  localparam logic [PC_W-1:0] STEP_TICK_READ  = 5'd5;
  localparam logic [PC_W-1:0] STEP_TICK_WAIT  = 5'd6;
  localparam logic [PC_W-1:0] STEP_TONE_MUL1  = 5'd7;
  localparam logic [PC_W-1:0] STEP_TONE_MUL2  = 5'd8;
  localparam logic [PC_W-1:0] STEP_TONE_LOAD  = 5'd9;
  localparam logic [PC_W-1:0] STEP_TONE_DIV   = 5'd10;
  localparam logic [PC_W-1:0] STEP_TONE_CLAMP = 5'd11;
  localparam logic [PC_W-1:0] STEP_TONE_ZERO  = 5'd12;
  localparam logic [PC_W-1:0] STEP_START      = 5'd13;
  localparam logic [PC_W-1:0] STEP_START_WAIT = 5'd14;
  localparam logic [PC_W-1:0] STEP_RATE_LOAD  = 5'd15;
  localparam logic [PC_W-1:0] STEP_RATE_DIV   = 5'd16;
  localparam logic [PC_W-1:0] STEP_DUR_MUL    = 5'd17;
  localparam logic [PC_W-1:0] STEP_DUR_LOAD   = 5'd18;
  localparam logic [PC_W-1:0] STEP_DUR_DIV    = 5'd19;
  localparam logic [PC_W-1:0] STEP_DUR_CLAMP  = 5'd20;
  localparam logic [PC_W-1:0] STEP_DUR_MAX    = 5'd21;
  localparam logic [PC_W-1:0] STEP_DUR_ZERO   = 5'd22;
  localparam logic [PC_W-1:0] STEP_EMIT_SEL   = 5'd23;
  localparam logic [PC_W-1:0] STEP_EMIT_TICK  = 5'd24;
  localparam logic [PC_W-1:0] STEP_EMIT_START = 5'd25;
  localparam logic [PC_W-1:0] STEP_WRITE      = 5'd26;
  localparam logic [PC_W-1:0] STEP_EMIT_FIN   = 5'd27;

  function automatic ucode_t uword(input act_t act, input cond_t cond,
                                   input logic [PC_W-1:0] target,
                                   input logic wait_in, input logic wait_out);
    ucode_t w;
    w.act      = act;
    w.cond     = cond;
    w.target   = target;
    w.wait_in  = wait_in;
    w.wait_out = wait_out;
    return w;
  endfunction

  // Control program: a jump goes to target when its condition holds, else to the next step.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      STEP_IDLE:       w = uword(ACT_ACCEPT,      COND_NEVER,     STEP_IDLE,       1'b1, 1'b0);
      STEP_CHECK:      w = uword(ACT_NONE,        COND_BAD,       STEP_IDLE,       1'b0, 1'b0);
      STEP_TO_WRITE:   w = uword(ACT_NONE,        COND_IS_WRITE,  STEP_WRITE,      1'b0, 1'b0);
      STEP_TO_START:   w = uword(ACT_NONE,        COND_IS_START,  STEP_START,      1'b0, 1'b0);
      STEP_TO_FIN:     w = uword(ACT_NONE,        COND_FINISHED,  STEP_EMIT_FIN,   1'b0, 1'b0);
      STEP_TICK_READ:  w = uword(ACT_READ_TICK,   COND_NEVER,     STEP_IDLE,       1'b0, 1'b0);
      STEP_TICK_WAIT:  w = uword(ACT_NONE,        COND_HZ_ZERO,   STEP_TONE_ZERO,  1'b0, 1'b0);
      STEP_TONE_MUL1:  w = uword(ACT_MUL_TONE1,   COND_NEVER,     STEP_IDLE,       1'b0, 1'b0);
      STEP_TONE_MUL2:  w = uword(ACT_MUL_TONE2,   COND_NEVER,     STEP_IDLE,       1'b0, 1'b0);
      STEP_TONE_LOAD:  w = uword(ACT_DIV_CLK,     COND_NEVER,     STEP_IDLE,       1'b0, 1'b0);
      STEP_TONE_DIV:   w = uword(ACT_DIV_STEP,    COND_DIV_BUSY,  STEP_TONE_DIV,   1'b0, 1'b0);
      STEP_TONE_CLAMP: w = uword(ACT_TONE_CLAMP,  COND_ALWAYS,    STEP_RATE_LOAD,  1'b0, 1'b0);
      STEP_TONE_ZERO:  w = uword(ACT_TONE_ZERO,   COND_ALWAYS,    STEP_RATE_LOAD,  1'b0, 1'b0);
      STEP_START:      w = uword(ACT_START_SETUP, COND_NEVER,     STEP_IDLE,       1'b0, 1'b0);
      STEP_START_WAIT: w = uword(ACT_NONE,        COND_NEVER,     STEP_IDLE,       1'b0, 1'b0);
      STEP_RATE_LOAD:  w = uword(ACT_DIV_RATE,    COND_MS_ZERO,   STEP_DUR_ZERO,   1'b0, 1'b0);
      STEP_RATE_DIV:   w = uword(ACT_DIV_STEP,    COND_DIV_BUSY,  STEP_RATE_DIV,   1'b0, 1'b0);
      STEP_DUR_MUL:    w = uword(ACT_MUL_DUR,     COND_RATE_ZERO, STEP_DUR_MAX,    1'b0, 1'b0);
      STEP_DUR_LOAD:   w = uword(ACT_DIV_CLK,     COND_NEVER,     STEP_IDLE,       1'b0, 1'b0);
      STEP_DUR_DIV:    w = uword(ACT_DIV_STEP,    COND_DIV_BUSY,  STEP_DUR_DIV,    1'b0, 1'b0);
      STEP_DUR_CLAMP:  w = uword(ACT_DUR_CLAMP,   COND_ALWAYS,    STEP_EMIT_SEL,   1'b0, 1'b0);
      STEP_DUR_MAX:    w = uword(ACT_DUR_MAX,     COND_ALWAYS,    STEP_EMIT_SEL,   1'b0, 1'b0);
      STEP_DUR_ZERO:   w = uword(ACT_DUR_ZERO,    COND_NEVER,     STEP_IDLE,       1'b0, 1'b0);
      STEP_EMIT_SEL:   w = uword(ACT_NONE,        COND_IS_START,  STEP_EMIT_START, 1'b0, 1'b0);
      STEP_EMIT_TICK:  w = uword(ACT_EMIT_TICK,   COND_ALWAYS,    STEP_IDLE,       1'b0, 1'b1);
      STEP_EMIT_START: w = uword(ACT_EMIT_START,  COND_ALWAYS,    STEP_IDLE,       1'b0, 1'b1);
      STEP_WRITE:      w = uword(ACT_WRITE,       COND_ALWAYS,    STEP_IDLE,       1'b0, 1'b0);
      STEP_EMIT_FIN:   w = uword(ACT_EMIT_FIN,    COND_ALWAYS,    STEP_IDLE,       1'b0, 1'b1);
      default:         w = uword(ACT_NONE,        COND_ALWAYS,    STEP_IDLE,       1'b0, 1'b0);
    endcase
    return w;
  endfunction

  // Turns a clock quotient into a timer reload: one less, saturated; zero divider gives max.
  function automatic logic [RELOAD_W-1:0] clamp_reload(input logic [NUM_W-1:0] q,
                                                       input logic den_zero);
    logic [RELOAD_W-1:0] r;
    if (den_zero) begin
      r = RELOAD_MAX;
    end else if (q == '0) begin
      r = '0;
    end else if (q > NUM_W'(RELOAD_MAX) + NUM_W'(1)) begin
      r = RELOAD_MAX;
    end else begin
      r = RELOAD_W'(q - NUM_W'(1));
    end
    return r;
  endfunction

endpackage

/* rtl/tvms_stream_if.sv */
// Valid/ready channel interfaces for note items and reload results.
interface tvms_in_if;
  logic                          valid;
  logic                          ready;
  logic [tvms_pkg::OP_W-1:0]     opcode;
  logic [tvms_pkg::CH_W-1:0]     channel;
  logic [tvms_pkg::IDX_W-1:0]    entry_index;
  logic [tvms_pkg::HZ_W-1:0]     note_hz;
  logic [tvms_pkg::MS_W-1:0]     note_ms;
  logic [tvms_pkg::LEN_W-1:0]    melody_length;

  modport source (output valid, opcode, channel, entry_index, note_hz, note_ms,
                  melody_length, input ready);
  modport sink (input valid, opcode, channel, entry_index, note_hz, note_ms,
                melody_length, output ready);
endinterface

interface tvms_out_if;
  logic                          valid;
  logic                          ready;
  logic [tvms_pkg::CH_W-1:0]     out_channel;
  logic [tvms_pkg::RELOAD_W-1:0] tone_reload;
  logic [tvms_pkg::RELOAD_W-1:0] duration_reload;
  logic                          duration_valid;
  logic                          melody_finished;

  modport source (output valid, out_channel, tone_reload, duration_reload, duration_valid,
                  melody_finished, input ready);
  modport sink (input valid, out_channel, tone_reload, duration_reload, duration_valid,
                melody_finished, output ready);
endinterface

/* rtl/tvms_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tvms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/two_voice_melody_sequencer_core.sv */
// Top level of the two-voice melody sequencer: microcoded control and its datapath.
//
// Items enter on note_in and results leave on reload_out, both valid/ready channels; a
// beat moves when valid and ready are high at a rising edge. A write item stores a note
// (frequency, duration) in the voice's table and gives no result. A start item sets the
// melody length, rewinds the voice and gives one result with the duration reload of note
// 0. A tick item gives one result with the tone and duration reloads of the current note
// and advances the voice, or a finished flag once a one-shot voice has run out.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block does not enforce it. One item is handled at
// a time; note_in.ready is high only while the sequencer waits at its first step.
// Tone and duration reloads come from one shared restoring divider that retires one
// quotient bit per cycle: 10 steps for 1000/ms and 28 steps for each clock quotient.
// A finished result sits in an output register, so the next item is accepted while it
// waits; if the receiver stalls, the sequencer holds at the step that would load the next
// result. Synchronous reset clears the sequence state and loads the default registers;
// the note tables are not cleared.
module two_voice_melody_sequencer_core (
  input  logic                              clk,
  input  logic                              rst,
  tvms_in_if.sink                           note_in,
  tvms_out_if.source                        reload_out,
  input  logic                              cfg_we,
  input  logic [tvms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tvms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [tvms_pkg::CLK_W-1:0]    timer_clock_hz;
  logic [tvms_pkg::PRE_W-1:0]    tone_prescale;
  logic [tvms_pkg::PRE_W-1:0]    duration_prescale;
  logic [tvms_pkg::MASK_W-1:0]   loop_mask;

  // Sequencer.
  logic [tvms_pkg::PC_W-1:0]     pc;
  logic [tvms_pkg::PC_W-1:0]     pc_next;
  tvms_pkg::ucode_t              uw;
  logic                          hold;
  logic                          fire;
  logic                          cond_true;

  // Captured item.
  logic [tvms_pkg::OP_W-1:0]     op_r;
  logic [tvms_pkg::CH_W-1:0]     ch_r;
  logic [tvms_pkg::IDX_W-1:0]    idx_r;
  logic [tvms_pkg::HZ_W-1:0]     hz_r;
  logic [tvms_pkg::MS_W-1:0]     ms_r;
  logic [tvms_pkg::LEN_W-1:0]    len_r;

  // Voice state.
  logic [tvms_pkg::POS_W-1:0]    note_position [tvms_pkg::VOICES];
  logic [tvms_pkg::POS_W-1:0]    melody_len [tvms_pkg::VOICES];

  // Note store.
  logic                          ram_we;
  logic                          ram_re;
  logic [tvms_pkg::ADDR_W-1:0]   ram_waddr;
  logic [tvms_pkg::ADDR_W-1:0]   ram_raddr;
  logic [tvms_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [tvms_pkg::HZ_W-1:0]     rd_hz;
  logic [tvms_pkg::MS_W-1:0]     rd_ms;

  // Arithmetic.
  logic [tvms_pkg::DEN_W-1:0]    mul_r;
  logic [tvms_pkg::DEN_W-1:0]    den_r;
  logic [tvms_pkg::NUM_W-1:0]    rem_r;
  logic [tvms_pkg::NUM_W-1:0]    quo_r;
  logic [tvms_pkg::CNT_W-1:0]    cnt_r;
  logic [tvms_pkg::CMP_W-1:0]    rem_shift;
  logic [tvms_pkg::CMP_W-1:0]    den_ext;
  logic                          div_ge;
  logic [tvms_pkg::RELOAD_W-1:0] tone_r;
  logic [tvms_pkg::RELOAD_W-1:0] dur_r;

  // Per-voice decode.
  logic                          loops;
  logic                          finished;
  logic                          bad_item;
  logic [tvms_pkg::POS_W-1:0]    cur_pos;
  logic [tvms_pkg::POS_W:0]      pos_inc;
  int                            slot;

  // Output register.
  logic                          out_valid;
  logic                          out_free;

  assign uw = tvms_pkg::ucode_rom(pc);

  // Handshake and stall decode.
  assign note_in.ready = (pc == tvms_pkg::STEP_IDLE);
  assign out_free      = !out_valid || reload_out.ready;
  assign hold          = (uw.wait_in && !note_in.valid) || (uw.wait_out && !out_free);
  assign fire          = !hold;

  // Voice decode for the captured item.
  assign cur_pos  = note_position[ch_r];
  assign loops    = loop_mask[ch_r];
  assign finished = !loops && (cur_pos >= melody_len[ch_r]);
  assign bad_item = (int'(ch_r) >= tvms_pkg::VOICES) ||
                    ((op_r != tvms_pkg::OP_WRITE) && (op_r != tvms_pkg::OP_START) &&
                     (op_r != tvms_pkg::OP_TICK)) ||
                    ((op_r == tvms_pkg::OP_WRITE) &&
                     (int'(idx_r) >= tvms_pkg::NOTES_PER_CHANNEL));
  assign slot     = (int'(cur_pos) < tvms_pkg::NOTES_PER_CHANNEL) ? int'(cur_pos) : 0;
  assign pos_inc  = (tvms_pkg::POS_W + 1)'(cur_pos) + (tvms_pkg::POS_W + 1)'(1);

  assign rd_hz = ram_rdata[tvms_pkg::ENTRY_W-1:tvms_pkg::MS_W];
  assign rd_ms = ram_rdata[tvms_pkg::MS_W-1:0];

  // Jump condition select.
  always_comb begin
    case (uw.cond)
      tvms_pkg::COND_NEVER:     cond_true = 1'b0;
      tvms_pkg::COND_ALWAYS:    cond_true = 1'b1;
      tvms_pkg::COND_BAD:       cond_true = bad_item;
      tvms_pkg::COND_IS_WRITE:  cond_true = (op_r == tvms_pkg::OP_WRITE);
      tvms_pkg::COND_IS_START:  cond_true = (op_r == tvms_pkg::OP_START);
      tvms_pkg::COND_FINISHED:  cond_true = finished;
      tvms_pkg::COND_HZ_ZERO:   cond_true = (rd_hz == '0);
      tvms_pkg::COND_MS_ZERO:   cond_true = (rd_ms == '0);
      tvms_pkg::COND_RATE_ZERO: cond_true = (quo_r[tvms_pkg::RATE_W-1:0] == '0);
      tvms_pkg::COND_DIV_BUSY:  cond_true = (cnt_r != tvms_pkg::CNT_W'(1));
      default:                  cond_true = 1'b0;
    endcase
  end

  // Next step of the program.
  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + tvms_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= tvms_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz    <= tvms_pkg::CLK_W'(84000000);
      tone_prescale     <= tvms_pkg::PRE_W'(2);
      duration_prescale <= tvms_pkg::PRE_W'(8401);
      loop_mask         <= tvms_pkg::MASK_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tvms_pkg::CFG_TIMER_CLOCK: timer_clock_hz    <= cfg_data[tvms_pkg::CLK_W-1:0];
        tvms_pkg::CFG_TONE_PRE:    tone_prescale     <= cfg_data[tvms_pkg::PRE_W-1:0];
        tvms_pkg::CFG_DUR_PRE:     duration_prescale <= cfg_data[tvms_pkg::PRE_W-1:0];
        tvms_pkg::CFG_LOOP_MASK:   loop_mask         <= cfg_data[tvms_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Note store access: writes at the item's slot, reads at note 0 or the current note.
  assign ram_we    = fire && (uw.act == tvms_pkg::ACT_WRITE);
  assign ram_re    = fire && ((uw.act == tvms_pkg::ACT_START_SETUP) ||
                              (uw.act == tvms_pkg::ACT_READ_TICK));
  assign ram_waddr = tvms_pkg::ADDR_W'(int'(ch_r) * tvms_pkg::NOTES_PER_CHANNEL + int'(idx_r));
  assign ram_raddr = (uw.act == tvms_pkg::ACT_START_SETUP) ?
                     tvms_pkg::ADDR_W'(int'(ch_r) * tvms_pkg::NOTES_PER_CHANNEL) :
                     tvms_pkg::ADDR_W'(int'(ch_r) * tvms_pkg::NOTES_PER_CHANNEL + slot);

  tvms_ram #(
    .WIDTH (tvms_pkg::ENTRY_W),
    .DEPTH (tvms_pkg::DEPTH)
  ) u_notes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({hz_r, ms_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Divider step compare: shift in the next numerator bit and test against the divisor.
  assign rem_shift = tvms_pkg::CMP_W'({rem_r, quo_r[tvms_pkg::NUM_W-1]});
  assign den_ext   = tvms_pkg::CMP_W'(den_r);
  assign div_ge    = (rem_shift >= den_ext);

  // Datapath actions.
  always_ff @(posedge clk) begin
    if (fire) begin
      case (uw.act)
        tvms_pkg::ACT_ACCEPT: begin
          op_r  <= note_in.opcode;
          ch_r  <= note_in.channel;
          idx_r <= note_in.entry_index;
          hz_r  <= note_in.note_hz;
          ms_r  <= note_in.note_ms;
          len_r <= note_in.melody_length;
        end
        tvms_pkg::ACT_START_SETUP: begin
          tone_r <= '0;
        end
        tvms_pkg::ACT_MUL_TONE1: begin
          mul_r <= tvms_pkg::DEN_W'(tvms_pkg::PROD1_W'(tone_prescale) *
                                    tvms_pkg::PROD1_W'(rd_hz));
        end
        tvms_pkg::ACT_MUL_TONE2: begin
          mul_r <= tvms_pkg::DEN_W'(tvms_pkg::DEN_W'(mul_r[tvms_pkg::PROD1_W-1:0]) *
                                    tvms_pkg::DEN_W'(tvms_pkg::SAMPLES_PER_PERIOD));
        end
        tvms_pkg::ACT_MUL_DUR: begin
          mul_r <= tvms_pkg::DEN_W'(
                     (tvms_pkg::PRE_W + tvms_pkg::RATE_W)'(duration_prescale) *
                     (tvms_pkg::PRE_W + tvms_pkg::RATE_W)'(quo_r[tvms_pkg::RATE_W-1:0]));
        end
        tvms_pkg::ACT_DIV_RATE: begin
          // Only the top quotient bits matter: the constant sits left-aligned.
          rem_r <= '0;
          quo_r <= tvms_pkg::NUM_W'(tvms_pkg::MS_PER_SECOND) <<
                   (tvms_pkg::NUM_W - tvms_pkg::RATE_W);
          den_r <= tvms_pkg::DEN_W'(rd_ms);
          cnt_r <= tvms_pkg::CNT_W'(tvms_pkg::RATE_W);
        end
        tvms_pkg::ACT_DIV_CLK: begin
          rem_r <= '0;
          quo_r <= timer_clock_hz;
          den_r <= mul_r;
          cnt_r <= tvms_pkg::CNT_W'(tvms_pkg::NUM_W);
        end
        tvms_pkg::ACT_DIV_STEP: begin
          if (div_ge) begin
            rem_r <= tvms_pkg::NUM_W'(rem_shift - den_ext);
          end else begin
            rem_r <= tvms_pkg::NUM_W'(rem_shift);
          end
          quo_r <= {quo_r[tvms_pkg::NUM_W-2:0], div_ge};
          cnt_r <= cnt_r - tvms_pkg::CNT_W'(1);
        end
        tvms_pkg::ACT_TONE_CLAMP: tone_r <= tvms_pkg::clamp_reload(quo_r, den_r == '0);
        tvms_pkg::ACT_TONE_ZERO:  tone_r <= '0;
        tvms_pkg::ACT_DUR_CLAMP:  dur_r  <= tvms_pkg::clamp_reload(quo_r, den_r == '0);
        tvms_pkg::ACT_DUR_MAX:    dur_r  <= tvms_pkg::RELOAD_MAX;
        tvms_pkg::ACT_DUR_ZERO:   dur_r  <= '0;
        default: ;
      endcase
    end
  end

  // Voice length and position.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < tvms_pkg::VOICES; v++) begin
        melody_len[v]    <= tvms_pkg::POS_W'(1);
        note_position[v] <= '0;
      end
    end else if (fire && (uw.act == tvms_pkg::ACT_START_SETUP)) begin
      if (int'(len_r) > tvms_pkg::NOTES_PER_CHANNEL) begin
        melody_len[ch_r] <= tvms_pkg::POS_W'(tvms_pkg::NOTES_PER_CHANNEL);
      end else begin
        melody_len[ch_r] <= tvms_pkg::POS_W'(len_r);
      end
      note_position[ch_r] <= '0;
    end else if (fire && (uw.act == tvms_pkg::ACT_EMIT_TICK)) begin
      if (loops && (pos_inc >= (tvms_pkg::POS_W + 1)'(melody_len[ch_r]))) begin
        note_position[ch_r] <= '0;
      end else begin
        note_position[ch_r] <= tvms_pkg::POS_W'(pos_inc);
      end
    end
  end

  // Output register flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ((uw.act == tvms_pkg::ACT_EMIT_TICK) ||
                          (uw.act == tvms_pkg::ACT_EMIT_START) ||
                          (uw.act == tvms_pkg::ACT_EMIT_FIN))) begin
      out_valid <= 1'b1;
    end else if (reload_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      case (uw.act)
        tvms_pkg::ACT_EMIT_TICK, tvms_pkg::ACT_EMIT_START: begin
          reload_out.out_channel     <= ch_r;
          reload_out.tone_reload     <= tone_r;
          reload_out.duration_reload <= dur_r;
          reload_out.duration_valid  <= 1'b1;
          reload_out.melody_finished <= 1'b0;
        end
        tvms_pkg::ACT_EMIT_FIN: begin
          reload_out.out_channel     <= ch_r;
          reload_out.tone_reload     <= '0;
          reload_out.duration_reload <= '0;
          reload_out.duration_valid  <= 1'b0;
          reload_out.melody_finished <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign reload_out.valid = out_valid;

endmodule

/* verif/two_voice_melody_sequencer_core_tb.sv */
// Self-checking testbench for the two-voice melody sequencer core.
`timescale 1ns / 100ps

module two_voice_melody_sequencer_core_tb;
  import tvms_pkg::*;

  // The block never decodes this opcode; such a beat must vanish without a reload.
  localparam logic [OP_W-1:0] OP_BAD = 2'd3;

  localparam int ITEMS_PER_PHASE = 125;
  localparam int SETTING_PHASES  = 7;
  localparam int SETTLE_CYCLES   = 120;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] idx;
    logic [HZ_W-1:0]  hz;
    logic [MS_W-1:0]  ms;
    logic [LEN_W-1:0] len;
  } note_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [RELOAD_W-1:0] tone;
    logic [RELOAD_W-1:0] dur;
    logic                dv;
    logic                fin;
  } reload_t;

  // How a directed row is judged: by the predictor, as giving nothing, or by its listed reload.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_LISTED
  } check_kind_t;

  typedef struct packed {
    note_item_t  item;
    check_kind_t kind;
    reload_t     listed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tvms_in_if  note_in_bus ();
  tvms_out_if reload_bus ();

  two_voice_melody_sequencer_core dut (
    .clk        (clk),
    .rst        (rst),
    .note_in    (note_in_bus),
    .reload_out (reload_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: note tables, per-voice progress and the timer settings.
  logic [HZ_W-1:0]   hz_tab [DEPTH];
  logic [MS_W-1:0]   ms_tab [DEPTH];
  bit                stored [DEPTH];
  int unsigned       voice_len [VOICES] = '{1, 1};
  int unsigned       voice_pos [VOICES] = '{0, 0};
  logic [CLK_W-1:0]  timer_hz_cfg  = 28'd84000000;
  logic [PRE_W-1:0]  tone_pre_cfg  = 17'd2;
  logic [PRE_W-1:0]  dur_pre_cfg   = 17'd8401;
  logic [MASK_W-1:0] loop_bits_cfg = 2'b01;

  reload_t  pending_reloads [$];
  dir_row_t directed_rows [$];

  int mismatches      = 0;
  int items_sent      = 0;
  int reloads_checked = 0;
  int finished_seen   = 0;
  int settings_loaded = 0;
  int burst_left      = 0;

  reload_t seen_reload;
  reload_t want_reload;

  // Clock quotient to timer reload: one less, floored at zero, saturated, max on a zero divider.
  function automatic logic [RELOAD_W-1:0] reload_from_quotient(input longint unsigned num,
                                                               input longint unsigned den);
    longint unsigned q;
    if (den == 0) return RELOAD_MAX;
    q = num / den;
    if (q == 0) return '0;
    q = q - 1;
    if (q > 65535) return RELOAD_MAX;
    return q[RELOAD_W-1:0];
  endfunction

  function automatic logic [RELOAD_W-1:0] tone_reload_of(input logic [HZ_W-1:0] hz);
    if (hz == '0) return '0;
    return reload_from_quotient(longint'(timer_hz_cfg),
      longint'(tone_pre_cfg) * longint'(SAMPLES_PER_PERIOD) * longint'(hz));
  endfunction

  function automatic logic [RELOAD_W-1:0] duration_reload_of(input logic [MS_W-1:0] ms);
    longint unsigned rate;
    if (ms == '0) return '0;
    rate = MS_PER_SECOND / longint'(ms);
    if (rate == 0) return RELOAD_MAX;
    return reload_from_quotient(longint'(timer_hz_cfg), longint'(dur_pre_cfg) * rate);
  endfunction

  // Table entry a tick on this voice would read, or -1 when the voice has finished.
  function automatic int tick_entry(input logic [CH_W-1:0] ch);
    int unsigned pos;
    pos = voice_pos[ch];
    if (!loop_bits_cfg[ch] && pos >= voice_len[ch]) return -1;
    return int'(ch) * NOTES_PER_CHANNEL + ((pos < NOTES_PER_CHANNEL) ? pos : 0);
  endfunction

  // Applies one accepted note item to the predictor; returns 1 when a reload is due.
  function automatic bit sequence_note(input note_item_t it, output reload_t r);
    int unsigned base;
    int          entry;
    int unsigned pos;
    r    = '0;
    r.ch = it.ch;
    base = int'(it.ch) * NOTES_PER_CHANNEL;
    case (it.op)
      OP_WRITE: begin
        hz_tab[base + it.idx] = it.hz;
        ms_tab[base + it.idx] = it.ms;
        stored[base + it.idx] = 1'b1;
        return 1'b0;
      end
      OP_START: begin
        voice_len[it.ch] = (it.len > NOTES_PER_CHANNEL) ? NOTES_PER_CHANNEL : it.len;
        voice_pos[it.ch] = 0;
        r.dur = duration_reload_of(ms_tab[base]);
        r.dv  = 1'b1;
        return 1'b1;
      end
      OP_TICK: begin
        entry = tick_entry(it.ch);
        if (entry < 0) begin
          r.fin = 1'b1;
          return 1'b1;
        end
        r.tone = tone_reload_of(hz_tab[entry]);
        r.dur  = duration_reload_of(ms_tab[entry]);
        r.dv   = 1'b1;
        pos = voice_pos[it.ch] + 1;
        if (loop_bits_cfg[it.ch] && pos >= voice_len[it.ch]) pos = 0;
        voice_pos[it.ch] = pos;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic dir_row_t dir_row(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                       input logic [IDX_W-1:0] idx, input logic [HZ_W-1:0] hz,
                                       input logic [MS_W-1:0] ms, input logic [LEN_W-1:0] len,
                                       input check_kind_t kind,
                                       input logic [RELOAD_W-1:0] tone,
                                       input logic [RELOAD_W-1:0] dur,
                                       input logic dv, input logic fin);
    dir_row_t row;
    row.item.op   = op;
    row.item.ch   = ch;
    row.item.idx  = idx;
    row.item.hz   = hz;
    row.item.ms   = ms;
    row.item.len  = len;
    row.kind      = kind;
    row.listed.ch   = ch;
    row.listed.tone = tone;
    row.listed.dur  = dur;
    row.listed.dv   = dv;
    row.listed.fin  = fin;
    return row;
  endfunction

  // Random item, mostly melody starts and ticks; a read of an empty slot becomes its write.
  function automatic note_item_t next_note();
    note_item_t it;
    int         pick;
    int         entry;
    it.ch  = CH_W'($urandom_range(0, 1));
    it.idx = IDX_W'($urandom_range(0, 63));
    it.hz  = HZ_W'($urandom_range(0, 8191));
    it.ms  = MS_W'($urandom_range(0, 65535));
    it.len = LEN_W'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.op = OP_WRITE;
      if ($urandom_range(0, 9) < 6) it.idx = IDX_W'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) it.hz = '0;
      case ($urandom_range(0, 9))
        0:             it.ms = '0;
        1, 2, 3, 4, 5: it.ms = MS_W'($urandom_range(1, 1000));
        6:             it.ms = MS_W'($urandom_range(1001, 65535));
        default:       it.ms = it.ms;
      endcase
    end else if (pick < 40) begin
      it.op = OP_START;
      case ($urandom_range(0, 9))
        7:       it.len = '0;
        8:       it.len = LEN_W'($urandom_range(9, 64));
        9:       it.len = LEN_W'($urandom_range(65, 127));
        default: it.len = LEN_W'($urandom_range(1, 8));
      endcase
    end else if (pick < 96) begin
      it.op = OP_TICK;
    end else begin
      it.op = OP_BAD;
    end
    if (it.op == OP_START && !stored[int'(it.ch) * NOTES_PER_CHANNEL]) begin
      it.op  = OP_WRITE;
      it.idx = '0;
    end else if (it.op == OP_TICK) begin
      entry = tick_entry(it.ch);
      if (entry >= 0 && !stored[entry]) begin
        it.op  = OP_WRITE;
        it.idx = IDX_W'(entry % NOTES_PER_CHANNEL);
      end
    end
    return it;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Drives one beat, waits for it to be taken, then paces the sender in bursts.
  task automatic send_note(input note_item_t it, input check_kind_t kind,
                           input reload_t listed);
    reload_t r;
    bit      due;
    note_in_bus.valid         <= 1'b1;
    note_in_bus.opcode        <= it.op;
    note_in_bus.channel       <= it.ch;
    note_in_bus.entry_index   <= it.idx;
    note_in_bus.note_hz       <= it.hz;
    note_in_bus.note_ms       <= it.ms;
    note_in_bus.melody_length <= it.len;
    do @(posedge clk); while (note_in_bus.ready !== 1'b1);
    due = sequence_note(it, r);
    if (kind == CHK_LISTED) pending_reloads.push_back(listed);
    else if (kind == CHK_MODEL && due) pending_reloads.push_back(r);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      note_in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 120)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic stop_sending();
    note_in_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_all_results();
    while (pending_reloads.size() != 0) @(posedge clk);
  endtask

  // Waits for the block to go idle, then writes all four timer settings.
  task automatic load_settings(input logic [CLK_W-1:0] clk_hz, input logic [PRE_W-1:0] tone_pre,
                               input logic [PRE_W-1:0] dur_pre,
                               input logic [MASK_W-1:0] loop_bits);
    logic [CFG_IDX_W-1:0]  regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs = '{CFG_TIMER_CLOCK, CFG_TONE_PRE, CFG_DUR_PRE, CFG_LOOP_MASK};
    vals[0] = CFG_DATA_W'(clk_hz);
    vals[1] = CFG_DATA_W'(tone_pre);
    vals[2] = CFG_DATA_W'(dur_pre);
    vals[3] = CFG_DATA_W'(loop_bits);
    stop_sending();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      case (regs[i])
        CFG_TIMER_CLOCK: timer_hz_cfg  = vals[i][CLK_W-1:0];
        CFG_TONE_PRE:    tone_pre_cfg  = vals[i][PRE_W-1:0];
        CFG_DUR_PRE:     dur_pre_cfg   = vals[i][PRE_W-1:0];
        default:         loop_bits_cfg = vals[i][MASK_W-1:0];
      endcase
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Stimulus: reset, the directed rows, then random phases under changing timer settings.
  initial begin
    int         done;
    note_item_t it;
    rst                       <= 1'b1;
    cfg_we                    <= 1'b0;
    cfg_index                 <= CFG_TIMER_CLOCK;
    cfg_data                  <= '0;
    note_in_bus.valid         <= 1'b0;
    note_in_bus.opcode        <= OP_WRITE;
    note_in_bus.channel       <= '0;
    note_in_bus.entry_index   <= '0;
    note_in_bus.note_hz       <= '0;
    note_in_bus.note_ms       <= '0;
    note_in_bus.melody_length <= '0;

    // Voice 0 loops and voice 1 plays once under the reset settings.
    directed_rows.push_back(dir_row(OP_WRITE, 0, 0, 440, 500, 0, CHK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, 0, 1, 0, 0, 0, CHK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, 0, 2, 8191, 65535, 0, CHK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, 0, 63, 1, 1, 0, CHK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, 1, 0, 8191, 1000, 0, CHK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, 1, 1, 4096, 1001, 0, CHK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_BAD, 1, 63, 8191, 65535, 127, CHK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_START, 0, 0, 0, 0, 3, CHK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0));
    // A rest with zero duration gives zero reloads.
    directed_rows.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, CHK_LISTED, 0, 0, 1, 0));
    // Top frequency and a duration over one second.
    directed_rows.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, CHK_LISTED, 39, 65535, 1, 0));
    directed_rows.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0));
    // A one-shot voice of length zero is finished at once and stays put.
    directed_rows.push_back(dir_row(OP_START, 1, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_TICK, 1, 0, 0, 0, 0, CHK_LISTED, 0, 0, 0, 1));
    directed_rows.push_back(dir_row(OP_TICK, 1, 0, 0, 0, 0, CHK_LISTED, 0, 0, 0, 1));
    // An oversized length is held at the table size.
    directed_rows.push_back(dir_row(OP_START, 1, 0, 0, 0, 127, CHK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_TICK, 1, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_TICK, 1, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0));
    // A looping voice of length zero replays its first note.
    directed_rows.push_back(dir_row(OP_START, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_START, 0, 0, 0, 0, 64, CHK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, 1, 63, 8191, 65535, 0, CHK_NONE, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 20);

    foreach (directed_rows[i]) begin
      send_note(directed_rows[i].item, directed_rows[i].kind, directed_rows[i].listed);
    end

    for (int p = 0; p < SETTING_PHASES; p++) begin
      case (p)
        0: ;
        1: load_settings(28'd200000000, 17'd1, 17'd1, 2'b11);
        2: load_settings(28'd1, 17'd65536, 17'd65536, 2'b00);
        3: load_settings(28'hFFFFFFF, 17'd0, 17'd0, 2'b10);
        4: load_settings(CLK_W'($urandom_range(1000000, 200000000)),
                         PRE_W'($urandom_range(1, 8)), PRE_W'($urandom_range(1000, 20000)),
                         MASK_W'($urandom_range(0, 3)));
        5: load_settings(28'd84000000, 17'd2, 17'd8401, 2'b01);
        default: load_settings(CLK_W'($urandom_range(0, 28'hFFFFFFF)),
                               PRE_W'($urandom_range(0, 17'h1FFFF)),
                               PRE_W'($urandom_range(0, 17'h1FFFF)),
                               MASK_W'($urandom_range(0, 3)));
      endcase
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        it = next_note();
        if (it.op != OP_BAD) done++;
        // Now and then hold off until every outstanding reload has been delivered.
        if ($urandom_range(0, 79) == 0) begin
          stop_sending();
          wait_all_results();
        end
        send_note(it, CHK_MODEL, '0);
      end
    end

    stop_sending();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d note beats (%0d directed) across %0d timer settings.",
             items_sent, directed_rows.size(), settings_loaded + 1);
    $display("Checked %0d reload beats, %0d of them end-of-melody flags.",
             reloads_checked, finished_seen);
    if (mismatches == 0) begin
      $display("two_voice_melody_sequencer_core_tb: PASS");
    end else begin
      $display("two_voice_melody_sequencer_core_tb: FAIL");
    end
    $finish;
  end

  // Receiver back-pressure: modes of random length, from always ready to long stalls.
  initial begin : reload_pacing
    int mode_left;
    int stall_mode;
    int hold_left;
    bit rdy_level;
    int beat_count;
    mode_left  = 0;
    stall_mode = 0;
    hold_left  = 0;
    rdy_level  = 1'b0;
    beat_count = 0;
    reload_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 300);
      end
      mode_left--;
      beat_count++;
      case (stall_mode)
        0: reload_bus.ready <= 1'b1;
        1: reload_bus.ready <= ($urandom_range(0, 3) != 0);
        2: begin
          if (hold_left == 0) begin
            rdy_level = !rdy_level;
            hold_left = rdy_level ? $urandom_range(1, 6) : $urandom_range(1, 24);
          end
          hold_left--;
          reload_bus.ready <= rdy_level;
        end
        default: reload_bus.ready <= ((beat_count % 8) < 3);
      endcase
    end
  end

  // Compares each delivered reload beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && reload_bus.valid === 1'b1 && reload_bus.ready === 1'b1) begin
      seen_reload.ch   = reload_bus.out_channel;
      seen_reload.tone = reload_bus.tone_reload;
      seen_reload.dur  = reload_bus.duration_reload;
      seen_reload.dv   = reload_bus.duration_valid;
      seen_reload.fin  = reload_bus.melody_finished;
      if (pending_reloads.size() == 0) begin
        mismatches++;
        $display("%0t: reload beat with none expected, actual channel %0d tone %0d duration %0d",
                 $time, seen_reload.ch, seen_reload.tone, seen_reload.dur);
      end else begin
        want_reload = pending_reloads.pop_front();
        check_field("out_channel", want_reload.ch, seen_reload.ch);
        check_field("tone_reload", want_reload.tone, seen_reload.tone);
        check_field("duration_reload", want_reload.dur, seen_reload.dur);
        check_field("duration_valid", want_reload.dv, seen_reload.dv);
        check_field("melody_finished", want_reload.fin, seen_reload.fin);
        reloads_checked++;
        if (seen_reload.fin) finished_seen++;
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("Timed out with %0d reloads still outstanding.", pending_reloads.size());
    $display("two_voice_melody_sequencer_core_tb: FAIL");
    $finish;
  end

endmodule
